// File: sv/rc_channel_frame_parser_top_assert.svh
// Assertion macros for the RC channel frame parser.
`ifndef RC_CHANNEL_FRAME_PARSER_TOP_ASSERT_SVH
`define RC_CHANNEL_FRAME_PARSER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// cond must hold at every clock edge out of reset
`define RCCFP_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rccfp: assertion failed");
// post must hold in the same cycle as pre
`define RCCFP_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rccfp: assertion failed");
`else
`define RCCFP_ASSERT(label, cond)
`define RCCFP_ASSERT_IMPL(label, pre, post)
`endif
`endif

// File: sv/rccfp_pkg.sv
// Shared types and constants of the RC channel frame parser.
package rccfp_pkg;

    localparam int CHANNELS_DEF   = 14;
    localparam int BYTE_W         = 8;
    localparam int VALUE_W        = 16;
    localparam int INDEX_W        = 4;
    localparam int POS_W          = 5;
    localparam int CFG_ADDR_W     = 1;
    localparam int TOKQ_DEPTH     = 2;
    localparam int TOKQ_PTR_W     = $clog2(TOKQ_DEPTH);
    localparam int TOKQ_CNT_W     = TOKQ_PTR_W + 1;

    localparam logic [BYTE_W-1:0]  START_BYTE_RST   = 8'h20;
    localparam logic [BYTE_W-1:0]  COMMAND_BYTE_RST = 8'h40;
    localparam logic [VALUE_W-1:0] CHECK_INIT       = 16'hFFFF;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_START_BYTE   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_COMMAND_BYTE = 1'b1;

    typedef enum logic [2:0] {
        PH_START,
        PH_CMD,
        PH_PAYLOAD,
        PH_CHK_LO,
        PH_CHK_HI
    } phase_t;

    typedef struct packed {
        logic [1:0] busy;
        phase_t     phase;
    } front_status_t;

    typedef struct packed {
        logic active;
        logic bank;
        logic release_bank;
    } back_status_t;

endpackage

// File: sv/rccfp_front.sv
// Front end: byte parser, checksum, payload writes and bank ownership.
module rccfp_front #(
    parameter int CHANNELS = rccfp_pkg::CHANNELS_DEF,
    parameter int CH_W     = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [rccfp_pkg::BYTE_W-1:0]      rx_byte,
    input  logic                              cfg_we,
    input  logic [rccfp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [rccfp_pkg::BYTE_W-1:0]      cfg_data,
    output logic                              wr_en,
    output logic                              wr_bank,
    output logic [CH_W-1:0]                   wr_idx,
    output logic [rccfp_pkg::VALUE_W-1:0]     wr_data,
    output logic                              tok_push,
    output logic                              tok_bank,
    input  rccfp_pkg::back_status_t           be_status,
    output rccfp_pkg::front_status_t          fe_status
);

    localparam logic [rccfp_pkg::POS_W-1:0] POS_LAST = rccfp_pkg::POS_W'(2 * CHANNELS - 1);

    rccfp_pkg::phase_t                phase_reg, phase_next;
    logic [rccfp_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [rccfp_pkg::VALUE_W-1:0]    check_reg, check_next;
    logic [rccfp_pkg::BYTE_W-1:0]     lo_reg, lo_next;
    logic                             bank_reg, bank_next;
    logic [1:0]                       busy_reg, busy_next;
    logic [rccfp_pkg::BYTE_W-1:0]     start_byte_reg;
    logic [rccfp_pkg::BYTE_W-1:0]     command_byte_reg;
    logic                             accept;
    logic [rccfp_pkg::VALUE_W-1:0]    byte_ext;

    // stall only when the bank we must write still belongs to the back end
    assign full     = (phase_reg == rccfp_pkg::PH_PAYLOAD) && busy_reg[bank_reg];
    assign accept   = push && !full;
    assign byte_ext = {{(rccfp_pkg::VALUE_W - rccfp_pkg::BYTE_W){1'b0}}, rx_byte};

    assign wr_en    = accept && (phase_reg == rccfp_pkg::PH_PAYLOAD) && pos_reg[0];
    assign wr_bank  = bank_reg;
    assign wr_idx   = pos_reg[CH_W:1];
    assign wr_data  = {rx_byte, lo_reg};
    assign tok_bank = bank_reg;

    assign fe_status.busy  = busy_reg;
    assign fe_status.phase = phase_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= rccfp_pkg::PH_START;
            pos_reg          <= '0;
            check_reg        <= rccfp_pkg::CHECK_INIT;
            bank_reg         <= 1'b0;
            busy_reg         <= '0;
            start_byte_reg   <= rccfp_pkg::START_BYTE_RST;
            command_byte_reg <= rccfp_pkg::COMMAND_BYTE_RST;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            check_reg <= check_next;
            bank_reg  <= bank_next;
            busy_reg  <= busy_next;
            if (cfg_we && (cfg_addr == rccfp_pkg::REG_START_BYTE))
            begin
                start_byte_reg <= cfg_data;
            end
            if (cfg_we && (cfg_addr == rccfp_pkg::REG_COMMAND_BYTE))
            begin
                command_byte_reg <= cfg_data;
            end
        end
    end

    // low byte of the channel being collected
    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        check_next = check_reg;
        lo_next    = lo_reg;
        bank_next  = bank_reg;
        busy_next  = busy_reg;
        tok_push   = 1'b0;

        if (be_status.release_bank)
        begin
            busy_next[be_status.bank] = 1'b0;
        end

        if (accept)
        begin
            case (phase_reg)
                rccfp_pkg::PH_CMD:
                begin
                    if (rx_byte == command_byte_reg)
                    begin
                        check_next = check_reg - byte_ext;
                        pos_next   = '0;
                        phase_next = rccfp_pkg::PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = rccfp_pkg::PH_START;
                    end
                end
                rccfp_pkg::PH_PAYLOAD:
                begin
                    if (!pos_reg[0])
                    begin
                        lo_next = rx_byte;
                    end
                    check_next = check_reg - byte_ext;
                    pos_next   = pos_reg + 1'b1;
                    if (pos_reg == POS_LAST)
                    begin
                        phase_next = rccfp_pkg::PH_CHK_LO;
                    end
                end
                rccfp_pkg::PH_CHK_LO:
                begin
                    if (rx_byte == check_reg[7:0])
                    begin
                        phase_next = rccfp_pkg::PH_CHK_HI;
                    end
                    else
                    begin
                        phase_next = rccfp_pkg::PH_START;
                    end
                end
                rccfp_pkg::PH_CHK_HI:
                begin
                    // good frame: hand the bank to the back end, switch banks
                    if (rx_byte == check_reg[15:8])
                    begin
                        tok_push            = 1'b1;
                        busy_next[bank_reg] = 1'b1;
                        bank_next           = !bank_reg;
                    end
                    phase_next = rccfp_pkg::PH_START;
                end
                default:
                begin
                    phase_next = rccfp_pkg::PH_START;
                    if (rx_byte == start_byte_reg)
                    begin
                        check_next = rccfp_pkg::CHECK_INIT - byte_ext;
                        pos_next   = '0;
                        phase_next = rccfp_pkg::PH_CMD;
                    end
                end
            endcase
        end
    end

endmodule

// File: sv/rccfp_tokq.sv
// Short queue of finished-frame bank numbers between front and back end.
module rccfp_tokq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               tok_push,
    input  logic                               tok_bank_in,
    input  logic                               tok_pop,
    output logic                               tok_empty,
    output logic                               tok_bank_out,
    output logic [rccfp_pkg::TOKQ_CNT_W-1:0]   tok_count
);

    logic                               entry_reg [rccfp_pkg::TOKQ_DEPTH];
    logic [rccfp_pkg::TOKQ_PTR_W-1:0]   wr_ptr_reg;
    logic [rccfp_pkg::TOKQ_PTR_W-1:0]   rd_ptr_reg;
    logic [rccfp_pkg::TOKQ_CNT_W-1:0]   count_reg;
    logic                               do_push;
    logic                               do_pop;

    assign tok_empty    = (count_reg == '0);
    assign tok_bank_out = entry_reg[rd_ptr_reg];
    assign tok_count    = count_reg;
    assign do_push      = tok_push;
    assign do_pop       = tok_pop && !tok_empty;

    // depth is a power of two, pointers wrap on their own
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= tok_bank_in;
        end
    end

endmodule

// File: sv/rccfp_back.sv
// Back end: two-bank channel memory and channel emitter with output register.
module rccfp_back #(
    parameter int CHANNELS = rccfp_pkg::CHANNELS_DEF,
    parameter int CH_W     = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic                                wr_bank,
    input  logic [CH_W-1:0]                     wr_idx,
    input  logic [rccfp_pkg::VALUE_W-1:0]       wr_data,
    input  logic                                tok_empty,
    input  logic                                tok_bank,
    output logic                                tok_pop,
    output rccfp_pkg::back_status_t             be_status,
    output logic                                empty,
    input  logic                                pop,
    output logic [rccfp_pkg::INDEX_W-1:0]       channel_index,
    output logic [rccfp_pkg::VALUE_W-1:0]       channel_value,
    output logic                                last_channel
);

    localparam int DEPTH = 2 * CHANNELS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    logic [rccfp_pkg::VALUE_W-1:0]  mem [DEPTH];
    logic                           active_reg;
    logic                           bank_reg;
    logic [CH_W-1:0]                ch_reg;
    logic                           out_valid_reg;
    logic [rccfp_pkg::VALUE_W-1:0]  out_value_reg;
    logic [CH_W-1:0]                out_ch_reg;
    logic                           out_last_reg;
    logic                           issue;
    logic                           finish;
    logic [AW-1:0]                  wr_addr;
    logic [AW-1:0]                  rd_addr;

    // bank 1 sits above bank 0
    assign wr_addr = (wr_bank ? AW'(CHANNELS) : AW'(0)) + AW'(wr_idx);
    assign rd_addr = (bank_reg ? AW'(CHANNELS) : AW'(0)) + AW'(ch_reg);

    assign issue   = active_reg && (!out_valid_reg || pop);
    assign finish  = issue && (ch_reg == CH_LAST);
    assign tok_pop = !active_reg && !tok_empty;

    assign be_status.active       = active_reg;
    assign be_status.bank         = bank_reg;
    assign be_status.release_bank = finish;

    assign empty         = !out_valid_reg;
    assign channel_index = rccfp_pkg::INDEX_W'(out_ch_reg);
    assign channel_value = out_value_reg;
    assign last_channel  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            bank_reg      <= 1'b0;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tok_pop)
            begin
                active_reg <= 1'b1;
                bank_reg   <= tok_bank;
                ch_reg     <= '0;
            end
            else if (issue)
            begin
                ch_reg <= ch_reg + 1'b1;
                if (finish)
                begin
                    active_reg <= 1'b0;
                end
            end

            if (issue)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // memory write port and registered read port, which is the output register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (issue)
        begin
            out_value_reg <= mem[rd_addr];
            out_ch_reg    <= ch_reg;
            out_last_reg  <= (ch_reg == CH_LAST);
        end
    end

endmodule

// File: sv/rc_channel_frame_parser_top.sv
// Top level of the RC channel frame parser: front parser, bank queue, channel emitter.
// Input: one byte per cycle unless full; full rises only while both payload banks are held.
// A good frame's bank passes the bank queue, then the back end bank register, then the output.
// Output: one channel per cycle while pop keeps up, from the registered memory read port.
// Reset (rst_n low, async): parser awaits start byte, queues empty, config bytes to defaults.
// Payload memory needs no clearing: a bank is read only after a full frame was written.
module rc_channel_frame_parser_top #(
    parameter int CHANNELS = rccfp_pkg::CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [rccfp_pkg::BYTE_W-1:0]        rx_byte,
    output logic                                empty,
    input  logic                                pop,
    output logic [rccfp_pkg::INDEX_W-1:0]       channel_index,
    output logic [rccfp_pkg::VALUE_W-1:0]       channel_value,
    output logic                                last_channel,
    input  logic                                cfg_we,
    input  logic [rccfp_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [rccfp_pkg::BYTE_W-1:0]        cfg_data
);

    `include "rc_channel_frame_parser_top_assert.svh"

    // channel counter width, at least one bit
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // index of the final channel, and the bank queue occupancy limit
    localparam logic [rccfp_pkg::INDEX_W-1:0] LAST_INDEX = rccfp_pkg::INDEX_W'(CHANNELS - 1);
    localparam logic [rccfp_pkg::TOKQ_CNT_W-1:0] TOKQ_LIMIT =
        rccfp_pkg::TOKQ_CNT_W'(rccfp_pkg::TOKQ_DEPTH);

    // Front end writes each channel word into its current bank as the high
    // byte arrives. A frame with a good checksum pushes its bank number into
    // the queue; the back end then drains that bank, one channel per cycle
    // while pop keeps up, and the front end fills the other bank.
    logic                               wr_en;
    logic                               wr_bank;
    logic [CH_W-1:0]                    wr_idx;
    logic [rccfp_pkg::VALUE_W-1:0]      wr_data;
    logic                               tok_push;
    logic                               tok_bank_in;
    logic                               tok_pop;
    logic                               tok_empty;
    logic                               tok_bank_out;
    logic [rccfp_pkg::TOKQ_CNT_W-1:0]   tok_count;
    rccfp_pkg::front_status_t           fe_status;
    rccfp_pkg::back_status_t            be_status;

    rccfp_front #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .rx_byte   (rx_byte),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .wr_bank   (wr_bank),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data),
        .tok_push  (tok_push),
        .tok_bank  (tok_bank_in),
        .be_status (be_status),
        .fe_status (fe_status)
    );

    rccfp_tokq u_tokq (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_push     (tok_push),
        .tok_bank_in  (tok_bank_in),
        .tok_pop      (tok_pop),
        .tok_empty    (tok_empty),
        .tok_bank_out (tok_bank_out),
        .tok_count    (tok_count)
    );

    rccfp_back #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .wr_en         (wr_en),
        .wr_bank       (wr_bank),
        .wr_idx        (wr_idx),
        .wr_data       (wr_data),
        .tok_empty     (tok_empty),
        .tok_bank      (tok_bank_out),
        .tok_pop       (tok_pop),
        .be_status     (be_status),
        .empty         (empty),
        .pop           (pop),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .last_channel  (last_channel)
    );

    // the bank being drained is still marked as held by the back end
    `RCCFP_ASSERT_IMPL(a_drain_bank_held, be_status.active, fe_status.busy[be_status.bank])
    // the parser stalls only while it needs to write payload
    `RCCFP_ASSERT_IMPL(a_full_in_payload, full, fe_status.phase == rccfp_pkg::PH_PAYLOAD)
    // bank queue never overflows
    `RCCFP_ASSERT_IMPL(a_tokq_room, tok_push, tok_count < TOKQ_LIMIT)
    // last flag sits on the final channel only
    `RCCFP_ASSERT_IMPL(a_last_index, !empty && last_channel, channel_index == LAST_INDEX)

endmodule
